@@ rtl/hfc_pkg.sv @@
// ----------------------------------------------------------------------------
// hfc_pkg
// Shared types and constants of the height filter chain.
// ----------------------------------------------------------------------------
`default_nettype none

package hfc_pkg;

  // Sample width and largest sample value
  localparam int unsigned VAL_W   = 10;
  localparam int unsigned MAX_VAL = 1023;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;

  // Request opcodes carried on tuser
  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_PRESET = 1'b1
  } hfc_op_e;

  // Control of one ring access step
  typedef struct packed {
    logic go;       // a request enters this step
    logic preset;   // the request is a preset
  } hfc_ctl_t;

endpackage

`default_nettype wire

@@ rtl/hfc_mavg.sv @@
// ----------------------------------------------------------------------------
// hfc_mavg
// Moving average over a ring memory with running sum and reciprocal divide.
// Read at issue, read-modify-write of the sum at update, registered
// quotient of the updated sum.
// ----------------------------------------------------------------------------
`default_nettype none

module hfc_mavg #(
  parameter int unsigned LEN = 10
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      adv_i,
  input  wire hfc_pkg::hfc_ctl_t         issue_i,
  input  wire hfc_pkg::hfc_ctl_t         update_i,
  input  wire logic [hfc_pkg::VAL_W-1:0] value_i,
  output logic      [hfc_pkg::VAL_W-1:0] quot_o
);
  import hfc_pkg::*;

  localparam int unsigned PW = $clog2(LEN);
  localparam int unsigned CW = $clog2(LEN + 1);
  localparam int unsigned SW = $clog2(LEN * MAX_VAL + 1);
  // Exact reciprocal: floor(n / LEN) == (n * MUL) >> SK for all n below 2**SW
  localparam int unsigned SK = SW + $clog2(LEN);
  localparam int unsigned MW = SW + 2;
  localparam int unsigned QW = SK + VAL_W;
  localparam longint unsigned MulFull = ((64'd1 << SK) + LEN - 1) / LEN;
  localparam logic [MW-1:0] MUL      = MW'(MulFull);
  localparam logic [PW-1:0] LAST_PTR = PW'(LEN - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(LEN);

  logic [VAL_W-1:0] mem [LEN];

  logic [PW-1:0]    ptr_q, ptr_d;
  logic [PW-1:0]    addr_q;
  logic [VAL_W-1:0] rdata_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [VAL_W-1:0] pre_q, pre_d;
  logic [SW-1:0]    sum_q, sum_d;
  logic [QW-1:0]    prod_q;
  logic [VAL_W-1:0] old_val;
  logic             do_write;

  // Pointer advance on filter requests only
  always_comb begin
    ptr_d = ptr_q;
    if (issue_i.go && !issue_i.preset) begin
      ptr_d = (ptr_q == LAST_PTR) ? '0 : ptr_q + 1'b1;
    end
  end

  // Entry leaving the ring: preset value until a full lap written since preset
  assign old_val  = (cnt_q == FULL_CNT) ? rdata_q : pre_q;
  assign do_write = update_i.go && !update_i.preset;

  // Running sum, fill count and preset value
  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    pre_d = pre_q;
    if (update_i.go) begin
      if (update_i.preset) begin
        sum_d = SW'(value_i) * SW'(LEN);
        cnt_d = '0;
        pre_d = value_i;
      end else begin
        sum_d = sum_q - SW'(old_val) + SW'(value_i);
        if (cnt_q != FULL_CNT) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      cnt_q <= '0;
      pre_q <= '0;
      sum_q <= '0;
    end else begin
      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
      pre_q <= pre_d;
      sum_q <= sum_d;
    end
  end

  // Ring memory write port
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[addr_q] <= value_i;
    end
  end

  // Ring memory read port, registered data
  always_ff @(posedge clk_i) begin
    if (issue_i.go) begin
      rdata_q <= mem[ptr_q];
      addr_q  <= ptr_q;
    end
  end

  // Reciprocal multiply of the updated sum, at full product width
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= QW'(sum_q) * QW'(MUL);
    end
  end

  assign quot_o = prod_q[QW-1:SK];

  // Checks
  a_preset_keeps_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_i.go && issue_i.preset |=> $stable(ptr_q))
    else $error("pointer moved on preset");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= LAST_PTR && cnt_q <= FULL_CNT)
    else $error("pointer or fill count out of range");

  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_write && cnt_q != FULL_CNT |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("fill count did not advance");

endmodule

`default_nettype wire

@@ rtl/height_filter_chain_core.sv @@
// ----------------------------------------------------------------------------
// height_filter_chain_core
// Short moving average, long moving average and shift IIR low-pass in chain.
// ----------------------------------------------------------------------------
// Pipeline: a request passes stages s1 to s5 and the output register to the
// master side. Throughput: one request per cycle unless the output stalls;
// six stages and the single read and write port of each ring memory set that.
// Reset: clears pointers, running sums, fill counts, preset values, the IIR
// register and all valid bits; ring memories are not swept, fill counts cover.
// ----------------------------------------------------------------------------
`default_nettype none

module height_filter_chain_core #(
  parameter int unsigned SHORT_LEN = 10,
  parameter int unsigned LONG_LEN  = 100,
  parameter int unsigned IIR_SHIFT = 4
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // tdata: height[9:0], zero pad
  input  wire logic [hfc_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: opcode
  input  wire logic                            s_axis_tuser_i,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata: smooth_height[9:0], average_height[19:10], slow_height[29:20], pad
  output logic      [hfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i
);
  import hfc_pkg::*;

  localparam int unsigned IW = VAL_W + IIR_SHIFT;

  logic             adv, accept;
  hfc_ctl_t         s_issue, s_update, l_issue, l_update;
  logic [VAL_W-1:0] short_quot, long_quot;

  logic             s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  logic             s1_op_q, s2_op_q, s3_op_q, s4_op_q, s5_op_q;
  logic [VAL_W-1:0] s1_h_q, s4_sm_q, s5_sm_q;

  logic [IW-1:0]    iir_q, iir_d;
  logic             out_v_q;
  logic [VAL_W-1:0] out_sm_q, out_av_q, out_sl_q;

  // Whole pipeline moves unless the output register is full and stalled
  assign adv             = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign accept          = s_axis_tvalid_i && adv;

  // Ring step controls
  assign s_issue.go      = accept;
  assign s_issue.preset  = (s_axis_tuser_i == OP_PRESET);
  assign s_update.go     = adv && s1_v_q;
  assign s_update.preset = (s1_op_q == OP_PRESET);
  assign l_issue.go      = adv && s2_v_q;
  assign l_issue.preset  = (s2_op_q == OP_PRESET);
  assign l_update.go     = adv && s3_v_q;
  assign l_update.preset = (s3_op_q == OP_PRESET);

  hfc_mavg #(
    .LEN (SHORT_LEN)
  ) u_short (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .issue_i  (s_issue),
    .update_i (s_update),
    .value_i  (s1_h_q),
    .quot_o   (short_quot)
  );

  // A preset leaves the short quotient equal to the preset value
  hfc_mavg #(
    .LEN (LONG_LEN)
  ) u_long (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .issue_i  (l_issue),
    .update_i (l_update),
    .value_i  (short_quot),
    .quot_o   (long_quot)
  );

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= s_axis_tvalid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      s5_v_q  <= s4_v_q;
      out_v_q <= s5_v_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q <= s_axis_tuser_i;
      s1_h_q  <= s_axis_tdata_i[VAL_W-1:0];
      s2_op_q <= s1_op_q;
      s3_op_q <= s2_op_q;
      s4_op_q <= s3_op_q;
      s5_op_q <= s4_op_q;
      s4_sm_q <= short_quot;
      s5_sm_q <= s4_sm_q;
    end
  end

  // IIR low-pass; on preset the long quotient equals the preset value
  always_comb begin
    if (s5_op_q == OP_PRESET) begin
      iir_d = IW'(long_quot) << IIR_SHIFT;
    end else begin
      iir_d = iir_q - (iir_q >> IIR_SHIFT) + IW'(long_quot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iir_q <= '0;
    end else if (adv && s5_v_q) begin
      iir_q <= iir_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_sm_q <= s5_sm_q;
      out_av_q <= long_quot;
      out_sl_q <= iir_d[IW-1:IIR_SHIFT];
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - 3 * VAL_W)'(0), out_sl_q, out_av_q, out_sm_q};

  // Checks
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(s5_v_q))
    else $error("result without a request in the last stage");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_v_q)
    else $error("accepted request did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !m_axis_tready_i |=> $stable(s5_v_q) && $stable(iir_q))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
